@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL.
// Each macro takes a label, a clock, an active-low reset, a trigger and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence holds in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cons)) \
		else $error("assertion failed");

// Consequence holds in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/lcc_pkg.sv @@
// ----------------------------------------------------------------------------
// lcc_pkg
// Types and constants of the line crossing counter.
// ----------------------------------------------------------------------------
package lcc_pkg;

	localparam int COORD_W  = 12;
	localparam int TRACK_W  = 8;
	localparam int CLASS_W  = 4;
	localparam int CNT_W    = 32;
	localparam int CENTER_W = 13;
	localparam int THR_W    = 4;
	localparam int AMASK_W  = 9;
	localparam int HIST_W   = 16;   // longest history
	localparam int FILL_W   = 5;
	localparam int TRACKS   = 256;
	localparam int ANCHORS  = 9;
	localparam int CFG_IDX_W = 3;

	localparam logic [THR_W-1:0]   THR_RESET   = 4'd1;
	localparam logic [AMASK_W-1:0] AMASK_RESET = 9'd15;
	localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_END_X   = 3'd2,
		REG_END_Y   = 3'd3,
		REG_THRESH  = 3'd4,
		REG_AMASK   = 3'd5
	} cfg_reg_t;

	// Anchor coordinate selects: 0 = base, 1 = base + size/2, 2 = base + size
	typedef logic [1:0] sel_t;
	localparam sel_t ANCHOR_XSEL [ANCHORS] = '{2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd2};
	localparam sel_t ANCHOR_YSEL [ANCHORS] = '{2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd1};

	typedef struct packed {
		logic [TRACK_W-1:0] track_id;
		logic [CLASS_W-1:0] class_id;
		logic [COORD_W-1:0] box_x;
		logic [COORD_W-1:0] box_y;
		logic [COORD_W-1:0] box_width;
		logic [COORD_W-1:0] box_height;
	} det_t;

	typedef struct packed {
		logic [TRACK_W-1:0]  crossed_track;
		logic                direction;
		logic [CNT_W-1:0]    in_total;
		logic [CNT_W-1:0]    out_total;
		logic [CNT_W-1:0]    class_total;
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
	} xing_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [COORD_W-1:0]   value;
	} cfg_wr_t;

	// One history memory entry
	typedef struct packed {
		logic [HIST_W-1:0] hist;
		logic [FILL_W-1:0] fill;
	} hist_entry_t;

endpackage

@@ hw/rtl/lcc_det_if.sv @@
// ----------------------------------------------------------------------------
// lcc_det_if
// Detection channel: one tracked box per transaction.
// ----------------------------------------------------------------------------
interface lcc_det_if import lcc_pkg::*; ();
	logic valid;
	logic ready;
	det_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/lcc_xing_if.sv @@
// ----------------------------------------------------------------------------
// lcc_xing_if
// Crossing event channel: one reported crossing per transaction.
// ----------------------------------------------------------------------------
interface lcc_xing_if import lcc_pkg::*; ();
	logic  valid;
	logic  ready;
	xing_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/lcc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lcc_cfg_if
// Register write channel: index and data per transaction.
// ----------------------------------------------------------------------------
interface lcc_cfg_if import lcc_pkg::*; ();
	logic    valid;
	logic    ready;
	cfg_wr_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/lcc_ram.sv @@
// ----------------------------------------------------------------------------
// lcc_ram
// Generic single-clock RAM, one write and one read port, registered read.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module lcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/line_crossing_counter_unit.sv @@
// ----------------------------------------------------------------------------
// line_crossing_counter_unit
// Counts tracked boxes crossing a configured line, per direction and class.
// ----------------------------------------------------------------------------
// The unit takes one detection per cycle while it is neither stalled nor held off
// after a register write, and reports at most one crossing per detection.
// Stage 0 forms the anchor offsets and registers twelve small products, stage
// 1 builds the dot and cross products and issues the read of the per-track
// history memory, stage 2 updates the history (forwarding the previous write)
// and stage 3 updates the saturating totals into the output register. The
// whole pipeline stalls while a finished event waits to be taken. After each
// register write the detection input is held off while the line terms settle.
module line_crossing_counter_unit import lcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lcc_cfg_if.sink   cfg,
	lcc_det_if.sink   det,
	lcc_xing_if.source xing
);

	`include "assert_macros.svh"

	localparam int TID_W = $clog2(TRACKS);

	// ---------------- configuration registers
	logic [COORD_W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic [THR_W-1:0]   thresh_q;
	logic [AMASK_W-1:0] amask_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
			thresh_q  <= THR_RESET;
			amask_q   <= AMASK_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_START_X: start_x_q <= cfg.data.value;
				REG_START_Y: start_y_q <= cfg.data.value;
				REG_END_X:   end_x_q   <= cfg.data.value;
				REG_END_Y:   end_y_q   <= cfg.data.value;
				REG_THRESH:  thresh_q  <= cfg.data.value[THR_W-1:0];
				REG_AMASK:   amask_q   <= cfg.data.value[AMASK_W-1:0];
				default: ;
			endcase
		end
	end

	// Settle count after a register write
	logic [1:0] settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= '0;
		end else if (cfg.valid) begin
			settle_q <= 2'd2;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	// Line direction and squared length, rebuilt from the registers
	logic signed [COORD_W:0]   dx_q, dy_q;
	logic [2*COORD_W-1:0]      dxsq_q, dysq_q;
	logic [2*COORD_W:0]        len2_q;
	logic signed [2*COORD_W+1:0] dxsq_w, dysq_w;

	assign dxsq_w = dx_q * dx_q;
	assign dysq_w = dy_q * dy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q   <= '0;
			dy_q   <= '0;
			dxsq_q <= '0;
			dysq_q <= '0;
			len2_q <= '0;
		end else begin
			dx_q   <= $signed({1'b0, end_x_q}) - $signed({1'b0, start_x_q});
			dy_q   <= $signed({1'b0, end_y_q}) - $signed({1'b0, start_y_q});
			dxsq_q <= dxsq_w[2*COORD_W-1:0];
			dysq_q <= dysq_w[2*COORD_W-1:0];
			len2_q <= {1'b0, dxsq_q} + {1'b0, dysq_q};
		end
	end

	// ---------------- pipeline advance
	logic adv;
	logic xing_valid_q;

	assign adv       = !xing_valid_q || xing.ready;
	assign det.ready = adv && (settle_q == '0);

	// ---------------- stage 0: anchor offsets and products
	logic [COORD_W:0]          ax [3];
	logic [COORD_W:0]          ay [3];
	logic signed [COORD_W+1:0] px [3];
	logic signed [COORD_W+1:0] py [3];

	always_comb begin
		ax[0] = {1'b0, det.data.box_x};
		ax[1] = {1'b0, det.data.box_x} + {2'b0, det.data.box_width[COORD_W-1:1]};
		ax[2] = {1'b0, det.data.box_x} + {1'b0, det.data.box_width};
		ay[0] = {1'b0, det.data.box_y};
		ay[1] = {1'b0, det.data.box_y} + {2'b0, det.data.box_height[COORD_W-1:1]};
		ay[2] = {1'b0, det.data.box_y} + {1'b0, det.data.box_height};
		for (int j = 0; j < 3; j++) begin
			px[j] = $signed({1'b0, ax[j]}) - $signed({2'b0, start_x_q});
			py[j] = $signed({1'b0, ay[j]}) - $signed({2'b0, start_y_q});
		end
	end

	localparam int PROD_W = 2*COORD_W + 3;

	logic                     valid_s1;
	logic signed [PROD_W-1:0] dxpx_s1 [3];
	logic signed [PROD_W-1:0] dypx_s1 [3];
	logic signed [PROD_W-1:0] dxpy_s1 [3];
	logic signed [PROD_W-1:0] dypy_s1 [3];
	logic [TRACK_W-1:0]       tid_s1;
	logic [CLASS_W-1:0]       cls_s1;
	logic [CENTER_W-1:0]      cx_s1, cy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= det.valid && det.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				dxpx_s1[j] <= dx_q * px[j];
				dypx_s1[j] <= dy_q * px[j];
				dxpy_s1[j] <= dx_q * py[j];
				dypy_s1[j] <= dy_q * py[j];
			end
			tid_s1 <= det.data.track_id;
			cls_s1 <= det.data.class_id;
			cx_s1  <= ax[1];
			cy_s1  <= ay[1];
		end
	end

	// ---------------- stage 1: zone test and side per anchor
	logic [AMASK_W-1:0]     amask_eff;
	logic signed [PROD_W:0] dot, crs;
	logic                   in_zone, any_left, any_right, keep_s1;

	assign amask_eff = (amask_q == '0) ? AMASK_RESET : amask_q;

	always_comb begin
		dot       = '0;
		crs       = '0;
		in_zone   = 1'b1;
		any_left  = 1'b0;
		any_right = 1'b0;
		for (int k = 0; k < ANCHORS; k++) begin
			dot = PROD_W'(0) + dxpx_s1[ANCHOR_XSEL[k]] + dypy_s1[ANCHOR_YSEL[k]];
			crs = PROD_W'(0) + dxpy_s1[ANCHOR_YSEL[k]] - dypx_s1[ANCHOR_XSEL[k]];
			if (amask_eff[k]) begin
				if (dot < 0 || dot > $signed({2'b0, len2_q})) begin
					in_zone = 1'b0;
				end
				if (crs < 0) begin
					any_left = 1'b1;
				end else begin
					any_right = 1'b1;
				end
			end
		end
		keep_s1 = valid_s1 && (len2_q != '0) && in_zone && !(any_left && any_right);
	end

	// History memory
	hist_entry_t        ram_rdata, ram_wdata;
	logic               ram_we;
	logic [TID_W-1:0]   ram_waddr;

	lcc_ram #(
		.WIDTH ($bits(hist_entry_t)),
		.DEPTH (TRACKS)
	) u_hist_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (adv),
		.raddr (tid_s1[TID_W-1:0]),
		.rdata (ram_rdata)
	);

	logic                valid_s2;
	logic                side_s2;
	logic [TRACK_W-1:0]  tid_s2;
	logic [CLASS_W-1:0]  cls_s2;
	logic [CENTER_W-1:0] cx_s2, cy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= keep_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= any_left;
			tid_s2  <= tid_s1;
			cls_s2  <= cls_s1;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
		end
	end

	// ---------------- stage 2: history read-modify-write
	logic [TRACKS-1:0]  hvalid_q;
	logic               lastwr_v_q;
	logic [TID_W-1:0]   lastwr_addr_q;
	hist_entry_t        lastwr_data_q;

	hist_entry_t        cur;
	logic [FILL_W-1:0]  fill_old, fill_inc, fill_new, h;
	logic [THR_W-1:0]   thr_eff;
	logic [HIST_W-1:0]  hist_new, older_mask, older;
	logic [THR_W-1:0]   oldest_pos;
	logic               oldest, cross_s2;

	always_comb begin
		// forward the write of the item just ahead
		if (lastwr_v_q && lastwr_addr_q == tid_s2[TID_W-1:0]) begin
			cur = lastwr_data_q;
		end else begin
			cur = ram_rdata;
		end
		fill_old = hvalid_q[tid_s2[TID_W-1:0]] ? cur.fill : '0;
		thr_eff  = (thresh_q == '0) ? THR_W'(1) : thresh_q;
		h        = FILL_W'(thr_eff) + FILL_W'(1);
		if (h > FILL_W'(HIST_W)) begin
			h = FILL_W'(HIST_W);
		end
		fill_inc   = fill_old + FILL_W'(1);
		fill_new   = (fill_inc >= h) ? h : fill_inc;
		hist_new   = {cur.hist[HIST_W-2:0], side_s2};
		oldest_pos = THR_W'(h - FILL_W'(1));
		oldest     = hist_new[oldest_pos];
		older_mask = (HIST_W'(1) << oldest_pos) - HIST_W'(1);
		older      = hist_new & older_mask;
		cross_s2   = (fill_new == h) && (oldest ? (older == '0) : (older == older_mask));
	end

	assign ram_we         = valid_s2 && adv;
	assign ram_waddr      = tid_s2[TID_W-1:0];
	assign ram_wdata.hist = hist_new;
	assign ram_wdata.fill = fill_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q   <= '0;
			lastwr_v_q <= 1'b0;
		end else if (adv) begin
			lastwr_v_q <= valid_s2;
			if (valid_s2) begin
				hvalid_q[tid_s2[TID_W-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lastwr_addr_q <= ram_waddr;
			lastwr_data_q <= ram_wdata;
		end
	end

	logic                ev_s3;
	logic                dir_s3;
	logic [TRACK_W-1:0]  tid_s3;
	logic [CLASS_W-1:0]  cls_s3;
	logic [CENTER_W-1:0] cx_s3, cy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s3 <= 1'b0;
		end else if (adv) begin
			ev_s3 <= valid_s2 && cross_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dir_s3 <= side_s2;
			tid_s3 <= tid_s2;
			cls_s3 <= cls_s2;
			cx_s3  <= cx_s2;
			cy_s3  <= cy_s2;
		end
	end

	// ---------------- stage 3: saturating totals and output register
	logic [CNT_W-1:0] in_cnt_q, out_cnt_q;
	logic [CNT_W-1:0] cls_in_q  [1 << CLASS_W];
	logic [CNT_W-1:0] cls_out_q [1 << CLASS_W];
	logic [CNT_W-1:0] in_nxt, out_nxt, cls_old, cls_nxt;

	always_comb begin
		in_nxt  = (in_cnt_q == CNT_MAX) ? in_cnt_q : in_cnt_q + CNT_W'(1);
		out_nxt = (out_cnt_q == CNT_MAX) ? out_cnt_q : out_cnt_q + CNT_W'(1);
		cls_old = dir_s3 ? cls_in_q[cls_s3] : cls_out_q[cls_s3];
		cls_nxt = (cls_old == CNT_MAX) ? cls_old : cls_old + CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q     <= '0;
			out_cnt_q    <= '0;
			xing_valid_q <= 1'b0;
			for (int c = 0; c < (1 << CLASS_W); c++) begin
				cls_in_q[c]  <= '0;
				cls_out_q[c] <= '0;
			end
		end else if (adv) begin
			xing_valid_q <= ev_s3;
			if (ev_s3) begin
				if (dir_s3) begin
					in_cnt_q         <= in_nxt;
					cls_in_q[cls_s3] <= cls_nxt;
				end else begin
					out_cnt_q         <= out_nxt;
					cls_out_q[cls_s3] <= cls_nxt;
				end
			end
		end
	end

	xing_t xing_q;

	always_ff @(posedge clk) begin
		if (adv && ev_s3) begin
			xing_q.crossed_track <= tid_s3;
			xing_q.direction     <= dir_s3;
			xing_q.in_total      <= dir_s3 ? in_nxt : in_cnt_q;
			xing_q.out_total     <= dir_s3 ? out_cnt_q : out_nxt;
			xing_q.class_total   <= cls_nxt;
			xing_q.center_x      <= cx_s3;
			xing_q.center_y      <= cy_s3;
		end
	end

	assign xing.valid = xing_valid_q;
	assign xing.data  = xing_q;

	// ---------------- assertions
	`ASSERT_SAME(a_zero_line_drops, clk, arst_n, len2_q == '0, !keep_s1)
	`ASSERT_NEXT(a_hist_marked, clk, arst_n, valid_s2 && adv, hvalid_q[$past(tid_s2[TID_W-1:0])])
	`ASSERT_NEXT(a_event_shown, clk, arst_n, ev_s3 && adv, xing.valid && (in_cnt_q != '0 || out_cnt_q != '0))

endmodule
